FILE: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants of the pupil mask classifier
// Fixed-point widths, config register indexes, segment codes and the
// records that travel between the rotation and classification stages.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // Subpixels per coarse cell along one axis
  localparam int SUBSAMPLE = 8;

  // Field widths
  localparam int SUB_W    = 9;
  localparam int CELL_W   = 6;
  localparam int CENTER_W = 16;
  localparam int TRIG_W   = 16;
  localparam int RAD_W    = 33;
  localparam int TAN_W    = 20;
  localparam int SHIFT_W  = 17;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 33;

  // Fixed-point bookkeeping
  localparam int COORD_FRAC = 10;
  localparam int TRIG_FRAC  = 14;
  localparam int XQ_W       = SUB_W + COORD_FRAC;
  localparam int D_W        = XQ_W + 2;
  localparam int PROD_W     = D_W + TRIG_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int ROT_W      = SUM_W - TRIG_FRAC;
  localparam int SQ_W       = 2 * ROT_W;
  localparam int R2_W       = SQ_W + 1;
  localparam int ARM_W      = ROT_W + 1;
  localparam int SPOKE_W    = ARM_W + TAN_W + 1;
  localparam int CONE_W     = ARM_W + TAN_W;
  localparam int YFIX_W     = ROT_W + TRIG_FRAC;
  localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);

  // Config register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_XY          = 3'd0,
    REG_COS_ROTATION       = 3'd1,
    REG_SIN_ROTATION       = 3'd2,
    REG_INNER_RADIUS_SQ    = 3'd3,
    REG_OUTER_RADIUS_SQ    = 3'd4,
    REG_TAN_SPIDER         = 3'd5,
    REG_SPIDER_OUTER_SHIFT = 3'd6,
    REG_SPIDER_INNER_SHIFT = 3'd7
  } cfg_reg_t;

  // Segment codes
  typedef enum logic [2:0] {
    SEG_NONE  = 3'd0,
    SEG_RIGHT = 3'd1,
    SEG_LEFT  = 3'd2,
    SEG_UP    = 3'd3,
    SEG_DOWN  = 3'd4
  } seg_t;

  // Configuration register file
  typedef struct packed {
    logic        [2*CENTER_W-1:0] center_xy;
    logic signed [TRIG_W-1:0]     cos_rotation;
    logic signed [TRIG_W-1:0]     sin_rotation;
    logic        [RAD_W-1:0]      inner_radius_sq;
    logic        [RAD_W-1:0]      outer_radius_sq;
    logic        [TAN_W-1:0]      tan_spider;
    logic signed [SHIFT_W-1:0]    spider_outer_shift;
    logic signed [SHIFT_W-1:0]    spider_inner_shift;
  } pmc_cfg_t;

  // Rotated point handed from the rotation unit to the classifier
  typedef struct packed {
    logic                    valid;
    logic signed [ROT_W-1:0] xr;
    logic signed [ROT_W-1:0] yr;
    logic [CELL_W-1:0]       cell_col;
    logic [CELL_W-1:0]       cell_row;
  } rot_t;

endpackage

FILE: rtl/pmc_rotate.sv
// ----------------------------------------------------------------------------
// pmc_rotate: offset and rotation of one subpixel
// Three stages: subtract center, form the four trig products, then sum and
// round the Q.24 results back to Q.10.
// ----------------------------------------------------------------------------
module pmc_rotate
  import pmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [SUB_W-1:0]  sub_column,
  input  logic [SUB_W-1:0]  sub_row,
  input  pmc_cfg_t          cfg,
  output rot_t              rot
);

  logic [XQ_W-1:0]       xq;
  logic [XQ_W-1:0]       yq;
  logic [CENTER_W-1:0]   cx;
  logic [CENTER_W-1:0]   cy;

  logic                  v1;
  logic signed [D_W-1:0] dx1;
  logic signed [D_W-1:0] dy1;
  logic [CELL_W-1:0]     cc1;
  logic [CELL_W-1:0]     cr1;

  logic                     v2;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_xs;
  logic signed [PROD_W-1:0] p_yc;
  logic signed [PROD_W-1:0] p_ys;
  logic [CELL_W-1:0]        cc2;
  logic [CELL_W-1:0]        cr2;

  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;

  // Scale indices to Q.10 and split the center word
  always_comb begin
    xq = XQ_W'((32'(sub_column) * 1024) / SUBSAMPLE);
    yq = XQ_W'((32'(sub_row) * 1024) / SUBSAMPLE);
    cx = cfg.center_xy[CENTER_W-1:0];
    cy = cfg.center_xy[2*CENTER_W-1:CENTER_W];
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // Stage 1: offset by the center
  always_ff @(posedge clk) begin
    dx1 <= $signed({{(D_W-XQ_W){1'b0}}, xq}) - $signed({{(D_W-CENTER_W){1'b0}}, cx});
    dy1 <= $signed({{(D_W-XQ_W){1'b0}}, yq}) - $signed({{(D_W-CENTER_W){1'b0}}, cy});
    cc1 <= CELL_W'(sub_column / SUBSAMPLE);
    cr1 <= CELL_W'(sub_row / SUBSAMPLE);
  end

  // Stage 2: trig products
  always_ff @(posedge clk) begin
    p_xc <= dx1 * cfg.cos_rotation;
    p_xs <= dx1 * cfg.sin_rotation;
    p_yc <= dy1 * cfg.cos_rotation;
    p_ys <= dy1 * cfg.sin_rotation;
    cc2  <= cc1;
    cr2  <= cr1;
  end

  // Sum with half an LSB added, so the shift rounds half up
  always_comb begin
    sum_x = SUM_W'(p_xc) - SUM_W'(p_ys) + SUM_W'(ROUND_HALF);
    sum_y = SUM_W'(p_xs) + SUM_W'(p_yc) + SUM_W'(ROUND_HALF);
  end

  // Stage 3: rounded rotated coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      rot.valid <= 1'b0;
    end else begin
      rot.valid <= v2;
    end
    rot.xr       <= sum_x[SUM_W-1:TRIG_FRAC];
    rot.yr       <= sum_y[SUM_W-1:TRIG_FRAC];
    rot.cell_col <= cc2;
    rot.cell_row <= cr2;
  end

endmodule

FILE: rtl/pmc_classify.sv
// ----------------------------------------------------------------------------
// pmc_classify: annulus and spider segment tests
// Three stages: form the wedge operands, multiply (squares and tangent
// cross terms), then compare and register the result.
// ----------------------------------------------------------------------------
module pmc_classify
  import pmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rot_t              rot,
  input  pmc_cfg_t          cfg,
  output logic              done,
  output logic              inside_res,
  output logic [2:0]        segment,
  output logic [CELL_W-1:0] cell_column,
  output logic [CELL_W-1:0] cell_row
);

  // Stage 4 signals
  logic signed [ARM_W-1:0] a1_n;
  logic signed [ARM_W-1:0] a2_n;
  logic signed [ARM_W-1:0] b_n;
  logic                    v4;
  logic signed [ROT_W-1:0] xr4;
  logic signed [ROT_W-1:0] yr4;
  logic signed [ARM_W-1:0] a1;
  logic signed [ARM_W-1:0] a2;
  logic [ARM_W-1:0]        babs;
  logic [ROT_W-1:0]        yabs4;
  logic                    a1z4;
  logic                    a1p4;
  logic                    a2z4;
  logic                    a2p4;
  logic                    bz4;
  logic                    xnz4;
  logic                    yz4;
  logic                    yn4;
  logic [CELL_W-1:0]       cc4;
  logic [CELL_W-1:0]       cr4;

  // Stage 5 signals
  logic                      v5;
  logic [SQ_W-1:0]           sqx;
  logic [SQ_W-1:0]           sqy;
  logic signed [SPOKE_W-1:0] p1;
  logic signed [SPOKE_W-1:0] p2;
  logic [CONE_W-1:0]         pb;
  logic [ROT_W-1:0]          yabs5;
  logic                      a1z5;
  logic                      a1p5;
  logic                      a2z5;
  logic                      a2p5;
  logic                      bz5;
  logic                      xnz5;
  logic                      yz5;
  logic                      yn5;
  logic [CELL_W-1:0]         cc5;
  logic [CELL_W-1:0]         cr5;

  // Stage 6 signals
  logic [R2_W-1:0]   r2;
  logic [YFIX_W-1:0] yfix;
  logic              ring;
  logic              tan_nz;
  logic              w1;
  logic              w2;
  logic              c3;
  logic              c4;
  logic              both_zero;
  seg_t              seg;

  // Wedge operands: arms along x, cone offset across y
  always_comb begin
    a1_n = ARM_W'(rot.xr) - ARM_W'(cfg.spider_outer_shift);
    a2_n = -(ARM_W'(rot.xr) + ARM_W'(cfg.spider_outer_shift));
    if (rot.xr < 0) begin
      b_n = ARM_W'(rot.xr) + ARM_W'(cfg.spider_inner_shift);
    end else begin
      b_n = ARM_W'(cfg.spider_inner_shift) - ARM_W'(rot.xr);
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v4   <= rot.valid;
      v5   <= v4;
      done <= v5;
    end
  end

  // Stage 4: operands, magnitudes and sign flags
  always_ff @(posedge clk) begin
    xr4   <= rot.xr;
    yr4   <= rot.yr;
    a1    <= a1_n;
    a2    <= a2_n;
    babs  <= b_n[ARM_W-1] ? ARM_W'(-b_n) : ARM_W'(b_n);
    yabs4 <= rot.yr[ROT_W-1] ? ROT_W'(-rot.yr) : ROT_W'(rot.yr);
    a1z4  <= (a1_n == '0);
    a1p4  <= !a1_n[ARM_W-1] && (a1_n != '0);
    a2z4  <= (a2_n == '0);
    a2p4  <= !a2_n[ARM_W-1] && (a2_n != '0);
    bz4   <= (b_n == '0);
    xnz4  <= (rot.xr != '0);
    yz4   <= (rot.yr == '0);
    yn4   <= rot.yr[ROT_W-1];
    cc4   <= rot.cell_col;
    cr4   <= rot.cell_row;
  end

  // Stage 5: squares and tangent cross products
  always_ff @(posedge clk) begin
    sqx   <= SQ_W'(xr4 * xr4);
    sqy   <= SQ_W'(yr4 * yr4);
    p1    <= $signed({1'b0, cfg.tan_spider}) * a1;
    p2    <= $signed({1'b0, cfg.tan_spider}) * a2;
    pb    <= cfg.tan_spider * babs;
    yabs5 <= yabs4;
    a1z5  <= a1z4;
    a1p5  <= a1p4;
    a2z5  <= a2z4;
    a2p5  <= a2p4;
    bz5   <= bz4;
    xnz5  <= xnz4;
    yz5   <= yz4;
    yn5   <= yn4;
    cc5   <= cc4;
    cr5   <= cr4;
  end

  // Annulus and segment tests, later segments win
  always_comb begin
    r2        = R2_W'(sqx) + R2_W'(sqy);
    yfix      = {yabs5, {TRIG_FRAC{1'b0}}};
    ring      = (r2 <= R2_W'(cfg.outer_radius_sq)) && (r2 >= R2_W'(cfg.inner_radius_sq));
    tan_nz    = (cfg.tan_spider != '0);
    both_zero = yz5 && bz5;
    w1 = (a1z5 && yz5) ? tan_nz :
         (a1p5 && ((SPOKE_W-1)'(yfix) < p1[SPOKE_W-2:0]));
    w2 = (a2z5 && yz5) ? tan_nz :
         (a2p5 && ((SPOKE_W-1)'(yfix) < p2[SPOKE_W-2:0]));
    c3 = xnz5 && (both_zero || (!yn5 && !yz5 && (pb < CONE_W'(yfix))));
    c4 = xnz5 && (both_zero || (yn5 && (pb < CONE_W'(yfix))));
    if (c4) begin
      seg = SEG_DOWN;
    end else if (c3) begin
      seg = SEG_UP;
    end else if (w2) begin
      seg = SEG_LEFT;
    end else if (w1) begin
      seg = SEG_RIGHT;
    end else begin
      seg = SEG_NONE;
    end
  end

  // Stage 6: result register
  always_ff @(posedge clk) begin
    inside_res  <= ring && (seg != SEG_NONE);
    segment     <= ring ? seg : SEG_NONE;
    cell_column <= cc5;
    cell_row    <= cr5;
  end

endmodule

FILE: rtl/pupil_mask_classifier.sv
// ----------------------------------------------------------------------------
// pupil_mask_classifier: pupil grid subpixel classifier
//
//   channel   signals                               direction  flow control
//   request   start, busy, sub_column, sub_row      in         start & !busy
//   result    done, inside_res, segment, cell_*     out        none (strobe)
//   config    cfg_valid, cfg_ready, cfg_index/data  in         valid & ready
//
// One request is taken every clock while rst is low. Its result passes six
// register stages and is loaded into the last of them together with done.
// The stages: center offset, trig products, rounding, wedge operands,
// multipliers, compare.
// Reset clears the valid chain and loads the config defaults; busy and
// cfg_ready are held off only while rst is high. The result side has no
// back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module pupil_mask_classifier
  import pmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [SUB_W-1:0]  sub_column,
  input  logic [SUB_W-1:0]  sub_row,
  output logic              done,
  output logic              inside_res,
  output logic [2:0]        segment,
  output logic [CELL_W-1:0] cell_column,
  output logic [CELL_W-1:0] cell_row,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  pmc_cfg_t cfg;
  rot_t     rot;
  logic     accept;

  // Handshakes
  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // Config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_xy          <= '0;
      cfg.cos_rotation       <= TRIG_W'(16384);
      cfg.sin_rotation       <= '0;
      cfg.inner_radius_sq    <= '0;
      cfg.outer_radius_sq    <= '0;
      cfg.tan_spider         <= TAN_W'(16384);
      cfg.spider_outer_shift <= '0;
      cfg.spider_inner_shift <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_XY:          cfg.center_xy          <= cfg_data[2*CENTER_W-1:0];
        REG_COS_ROTATION:       cfg.cos_rotation       <= cfg_data[TRIG_W-1:0];
        REG_SIN_ROTATION:       cfg.sin_rotation       <= cfg_data[TRIG_W-1:0];
        REG_INNER_RADIUS_SQ:    cfg.inner_radius_sq    <= cfg_data[RAD_W-1:0];
        REG_OUTER_RADIUS_SQ:    cfg.outer_radius_sq    <= cfg_data[RAD_W-1:0];
        REG_TAN_SPIDER:         cfg.tan_spider         <= cfg_data[TAN_W-1:0];
        REG_SPIDER_OUTER_SHIFT: cfg.spider_outer_shift <= cfg_data[SHIFT_W-1:0];
        REG_SPIDER_INNER_SHIFT: cfg.spider_inner_shift <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Offset and rotate
  pmc_rotate u_rotate (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sub_column (sub_column),
    .sub_row    (sub_row),
    .cfg        (cfg),
    .rot        (rot)
  );

  // Annulus and spider tests
  pmc_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .rot         (rot),
    .cfg         (cfg),
    .done        (done),
    .inside_res  (inside_res),
    .segment     (segment),
    .cell_column (cell_column),
    .cell_row    (cell_row)
  );

endmodule

FILE: rtl/pmc_checker.sv
// ----------------------------------------------------------------------------
// pmc_checker: port-level checks of the pupil mask classifier
// Watches request and result ports for latency, cell mapping and
// consistency of the inside flag with the segment code.
// ----------------------------------------------------------------------------
module pmc_checker
  import pmc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [SUB_W-1:0]  sub_column,
  input logic [SUB_W-1:0]  sub_row,
  input logic              done,
  input logic              inside_res,
  input logic [2:0]        segment,
  input logic [CELL_W-1:0] cell_column,
  input logic [CELL_W-1:0] cell_row
);

  localparam int LATENCY = 6;

  // Every request yields a result on done
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after request");

  // No result without a matching request
  a_no_extra : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  // Cells follow the subpixel indices of the request
  a_cells : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY
      ((cell_column == CELL_W'($past(sub_column, LATENCY) / SUBSAMPLE)) &&
       (cell_row == CELL_W'($past(sub_row, LATENCY) / SUBSAMPLE))))
    else $error("cell coordinates do not match request");

  // Inside flag agrees with a legal segment code
  a_segment : assert property (@(posedge clk) disable iff (rst)
    done |-> ((inside_res == (segment != SEG_NONE)) && (segment <= SEG_DOWN)))
    else $error("segment code inconsistent with inside flag");

endmodule

bind pupil_mask_classifier pmc_checker u_pmc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .sub_column  (sub_column),
  .sub_row     (sub_row),
  .done        (done),
  .inside_res  (inside_res),
  .segment     (segment),
  .cell_column (cell_column),
  .cell_row    (cell_row)
);
